// ----- rtl/core/class_argmax_palette_overlay_core_macros.svh -----
`ifndef CLASS_ARGMAX_PALETTE_OVERLAY_CORE_MACROS_SVH
`define CLASS_ARGMAX_PALETTE_OVERLAY_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define CAPO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("capo: same-cycle check failed");

// next-cycle implication, off during reset
`define CAPO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("capo: next-cycle check failed");

`endif

// ----- rtl/core/capo_pkg.sv -----
`timescale 1ns / 1ps

package capo_pkg;

    localparam int unsigned CLS_W    = 5;
    localparam int unsigned PIX_W    = 8;
    localparam int unsigned PAL_SIZE = 19;

    // x/5 == (x * DIV5_MUL) >> DIV5_SHIFT, exact for the 11-bit blend sums
    localparam logic [15:0] DIV5_MUL   = 16'd52429;
    localparam int unsigned DIV5_SHIFT = 18;

    localparam logic [PIX_W-1:0] PAL_B [PAL_SIZE] = '{
        8'd128, 8'd232, 8'd70,  8'd156, 8'd153, 8'd153, 8'd30,  8'd0,   8'd35,  8'd152,
        8'd180, 8'd60,  8'd0,   8'd142, 8'd70,  8'd100, 8'd100, 8'd230, 8'd32};
    localparam logic [PIX_W-1:0] PAL_G [PAL_SIZE] = '{
        8'd64,  8'd35,  8'd70,  8'd102, 8'd153, 8'd153, 8'd170, 8'd220, 8'd142, 8'd251,
        8'd130, 8'd20,  8'd0,   8'd0,   8'd0,   8'd60,  8'd80,  8'd0,   8'd11};
    localparam logic [PIX_W-1:0] PAL_R [PAL_SIZE] = '{
        8'd128, 8'd244, 8'd70,  8'd102, 8'd190, 8'd153, 8'd250, 8'd220, 8'd107, 8'd152,
        8'd70,  8'd220, 8'd255, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd119};

    typedef struct packed {
        logic             last;
        logic [CLS_W-1:0] best_class;
    } t_argmax_res;

    // floor((2*img + 8*pal)/10) == floor((img + 4*pal)/5)
    function automatic logic [PIX_W-1:0] blend8(logic [PIX_W-1:0] img,
                                               logic [PIX_W-1:0] pal);
        logic [10:0] sum;
        logic [26:0] prod;
        sum  = {3'b000, img} + {1'b0, pal, 2'b00};
        prod = {16'd0, sum} * {11'd0, DIV5_MUL};
        return prod[DIV5_SHIFT +: PIX_W];
    endfunction

endpackage

// ----- rtl/core/capo_argmax.sv -----
`timescale 1ns / 1ps

module capo_argmax #(
    parameter int unsigned NUM_CLASSES = 19
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic signed [7:0]      i_score,
    output capo_pkg::t_argmax_res  o_res
);
    import capo_pkg::*;

    localparam logic [CLS_W:0] LAST_CNT = (CLS_W + 1)'(NUM_CLASSES);

    logic signed [7:0] r_best_score, n_best_score;
    logic [CLS_W-1:0]  r_best_class, n_best_class;
    logic [CLS_W-1:0]  r_class_counter, n_class_counter;
    logic              take;
    logic              last;

    always_comb begin
        // class 0 reloads unconditionally; ties keep the earlier class
        take            = (r_class_counter == '0) || (i_score > r_best_score);
        n_best_score    = take ? i_score : r_best_score;
        n_best_class    = take ? r_class_counter : r_best_class;
        last            = ({1'b0, r_class_counter} + 1'b1) >= LAST_CNT;
        n_class_counter = last ? '0 : r_class_counter + 1'b1;
        o_res.last       = last;
        o_res.best_class = n_best_class;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_score    <= '0;
            r_best_class    <= '0;
            r_class_counter <= '0;
        end else if (i_step) begin
            r_best_score    <= n_best_score;
            r_best_class    <= n_best_class;
            r_class_counter <= n_class_counter;
        end
    end

endmodule

// ----- rtl/core/capo_blend.sv -----
`timescale 1ns / 1ps

module capo_blend (
    input  logic [capo_pkg::CLS_W-1:0] i_class,
    input  logic [capo_pkg::PIX_W-1:0] i_pix_b,
    input  logic [capo_pkg::PIX_W-1:0] i_pix_g,
    input  logic [capo_pkg::PIX_W-1:0] i_pix_r,
    output logic [capo_pkg::PIX_W-1:0] o_out_b,
    output logic [capo_pkg::PIX_W-1:0] o_out_g,
    output logic [capo_pkg::PIX_W-1:0] o_out_r
);
    import capo_pkg::*;

    logic [PIX_W-1:0] pal_b, pal_g, pal_r;

    always_comb begin
        // classes past the palette overlay black
        pal_b = '0;
        pal_g = '0;
        pal_r = '0;
        if (i_class < CLS_W'(PAL_SIZE)) begin
            pal_b = PAL_B[i_class];
            pal_g = PAL_G[i_class];
            pal_r = PAL_R[i_class];
        end
        o_out_b = blend8(i_pix_b, pal_b);
        o_out_g = blend8(i_pix_g, pal_g);
        o_out_r = blend8(i_pix_r, pal_r);
    end

endmodule

// ----- rtl/core/class_argmax_palette_overlay_core.sv -----
`timescale 1ns / 1ps
// Result path: the last score beat of a pixel passes the input register, then the result register.
// Throughput: one score beat per cycle; the input register, the argmax/blend logic
// and the result register advance together, stalling only while a result is held.
// One result per NUM_CLASSES score beats. Reset (synchronous, active low) clears
// the class counter, the running maximum and both valid flags.

module class_argmax_palette_overlay_core #(
    parameter int unsigned NUM_CLASSES = 19
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [7:0]          i_score,
    input  logic [capo_pkg::PIX_W-1:0] i_pix_b,
    input  logic [capo_pkg::PIX_W-1:0] i_pix_g,
    input  logic [capo_pkg::PIX_W-1:0] i_pix_r,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [capo_pkg::CLS_W-1:0] o_class_index,
    output logic [capo_pkg::PIX_W-1:0] o_out_b,
    output logic [capo_pkg::PIX_W-1:0] o_out_g,
    output logic [capo_pkg::PIX_W-1:0] o_out_r
);
    import capo_pkg::*;

    logic              adv;
    logic              r_in_valid;
    logic signed [7:0] r_score;
    logic [PIX_W-1:0]  r_pix_b, r_pix_g, r_pix_r;
    t_argmax_res       am_res;
    logic [PIX_W-1:0]  bl_b, bl_g, bl_r;

    logic              r_out_valid;
    logic [CLS_W-1:0]  r_class_index;
    logic [PIX_W-1:0]  r_out_b, r_out_g, r_out_r;

    // whole pipe moves unless a result beat is blocked
    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_score <= i_score;
            r_pix_b <= i_pix_b;
            r_pix_g <= i_pix_g;
            r_pix_r <= i_pix_r;
        end
    end

    capo_argmax #(
        .NUM_CLASSES(NUM_CLASSES)
    ) u_argmax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv && r_in_valid),
        .i_score (r_score),
        .o_res   (am_res)
    );

    capo_blend u_blend (
        .i_class (am_res.best_class),
        .i_pix_b (r_pix_b),
        .i_pix_g (r_pix_g),
        .i_pix_r (r_pix_r),
        .o_out_b (bl_b),
        .o_out_g (bl_g),
        .o_out_r (bl_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid && am_res.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_valid && am_res.last) begin
            r_class_index <= am_res.best_class;
            r_out_b       <= bl_b;
            r_out_g       <= bl_g;
            r_out_r       <= bl_r;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_class_index = r_class_index;
    assign o_out_b       = r_out_b;
    assign o_out_g       = r_out_g;
    assign o_out_r       = r_out_r;

endmodule

// ----- rtl/core/capo_checker.sv -----
`timescale 1ns / 1ps
`include "class_argmax_palette_overlay_core_macros.svh"

module capo_checker #(
    parameter int unsigned NUM_CLASSES = 19
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [capo_pkg::CLS_W-1:0] o_class_index,
    input logic [capo_pkg::PIX_W-1:0] o_out_b,
    input logic [capo_pkg::PIX_W-1:0] o_out_g,
    input logic [capo_pkg::PIX_W-1:0] o_out_r
);
    import capo_pkg::*;

    localparam logic [CLS_W:0] CLS_LIMIT = (CLS_W + 1)'(NUM_CLASSES);

    // held result beat keeps its payload
    `CAPO_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_class_index) && $stable(o_out_b) && $stable(o_out_g) && $stable(o_out_r))

    // input backpressure only comes from a blocked result
    `CAPO_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // winning class stays within the class count
    `CAPO_ASSERT_IMP(a_class_range, i_clk, i_rst_n, o_valid, {1'b0, o_class_index} < CLS_LIMIT)

    // a new result needs the pipe to have moved on the cycle before
    `CAPO_ASSERT_IMP(a_rise_moved, i_clk, i_rst_n, $rose(o_valid), $past(!o_stall))

endmodule

bind class_argmax_palette_overlay_core capo_checker #(
    .NUM_CLASSES(NUM_CLASSES)
) u_capo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_class_index (o_class_index),
    .o_out_b       (o_out_b),
    .o_out_g       (o_out_g),
    .o_out_r       (o_out_r)
);
